/* hw/rtl/hrfh_pkg.sv */
// Shared types, constants and helpers for the hex record to flash halfword unit.
`timescale 1ns / 1ps

package hrfh_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned HW_W = 16;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned IDX_W = 7;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [ADDR_W-1:0] FLASH_BASE_RST = 32'h0800_0000;

	// One halfword write decided by the parser, waiting for address generation.
	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [IDX_W-1:0]    index;
		logic [HW_W-1:0]     halfword;
		logic                last;
	} hrfh_entry_t;

	// Digits map to c - '0'; everything else to (c - 55) mod 16.
	function automatic logic [3:0] hrfh_nibble(input logic [CHAR_W-1:0] c);
		logic is_digit;
		is_digit = (c >= 8'h30) && (c <= 8'h39);
		return is_digit ? c[3:0] : (c[3:0] + 4'd9);
	endfunction

endpackage

/* hw/rtl/hrfh_if.sv */
// Channel interfaces: record characters in, flash halfwords out, base address write.
`timescale 1ns / 1ps

interface hrfh_in_if import hrfh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] record_char;
	logic              record_start;

	modport source (output valid, output record_char, output record_start, input ready);
	modport sink (input valid, input record_char, input record_start, output ready);
endinterface

interface hrfh_out_if import hrfh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] flash_address;
	logic [HW_W-1:0]   halfword;
	logic              last_of_record;

	modport source (output valid, output flash_address, output halfword,
		output last_of_record, input ready);
	modport sink (input valid, input flash_address, input halfword,
		input last_of_record, output ready);
endinterface

interface hrfh_cfg_if import hrfh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/hrfh_front.sv */
// Record parser: tracks character position, collects header fields and data nibbles.
`timescale 1ns / 1ps

module hrfh_front import hrfh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	hrfh_in_if.sink      chars,
	input  logic         push_ready,
	output logic         push_valid,
	output hrfh_entry_t  push_entry
);

	localparam int unsigned POS_W = 10;
	localparam logic [POS_W-1:0] POS_START = 10'd0;
	localparam logic [POS_W-1:0] POS_COUNT_HI = 10'd1;
	localparam logic [POS_W-1:0] POS_COUNT_LO = 10'd2;
	localparam logic [POS_W-1:0] POS_OFFSET_FIRST = 10'd3;
	localparam logic [POS_W-1:0] POS_OFFSET_LAST = 10'd6;
	localparam logic [POS_W-1:0] POS_TYPE = 10'd8;
	localparam logic [POS_W-1:0] POS_DATA = 10'd9;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	logic [POS_W-1:0]    char_position_q;
	logic [7:0]          byte_count_q;
	logic [OFFSET_W-1:0] record_offset_q;
	logic                is_data_q;
	logic [IDX_W-1:0]    halfword_index_q;
	logic [11:0]         partial_q;

	logic                accept;
	logic [POS_W-1:0]    pos;
	logic [3:0]          nib;
	logic                in_data;
	logic                group_end;
	logic [IDX_W-1:0]    total;
	logic                emit;
	logic [HW_W-1:0]     assembled;

	assign chars.ready = push_ready;
	assign accept = chars.valid && push_ready;

	assign pos = chars.record_start ? POS_START : char_position_q;
	assign nib = hrfh_nibble(chars.record_char);
	assign in_data = pos >= POS_DATA;
	// Group of four data characters ends where pos is a multiple of four.
	assign group_end = in_data && (pos[1:0] == 2'd0);
	assign total = byte_count_q[7:1];
	assign emit = group_end && is_data_q && (halfword_index_q < total);
	assign assembled = {partial_q, nib};

	assign push_valid = accept && emit;
	assign push_entry.offset = record_offset_q;
	assign push_entry.index = halfword_index_q;
	assign push_entry.halfword = {assembled[7:0], assembled[15:8]};
	assign push_entry.last = ({1'b0, halfword_index_q} + 8'd1) == {1'b0, total};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q <= '0;
			byte_count_q <= '0;
			record_offset_q <= '0;
			is_data_q <= 1'b0;
			halfword_index_q <= '0;
			partial_q <= '0;
		end else if (accept) begin
			char_position_q <= (pos != POS_MAX) ? pos + 10'd1 : POS_MAX;
			if (pos == POS_START) begin
				byte_count_q <= '0;
				record_offset_q <= '0;
				is_data_q <= 1'b0;
				halfword_index_q <= '0;
				partial_q <= '0;
			end else if (pos == POS_COUNT_HI) begin
				byte_count_q <= {nib, 4'd0};
			end else if (pos == POS_COUNT_LO) begin
				byte_count_q <= {byte_count_q[7:4], byte_count_q[3:0] | nib};
			end else if (pos >= POS_OFFSET_FIRST && pos <= POS_OFFSET_LAST) begin
				record_offset_q <= {record_offset_q[11:0], nib};
			end else if (pos == POS_TYPE) begin
				is_data_q <= chars.record_char == 8'h30;
			end else if (in_data) begin
				if (group_end) begin
					partial_q <= '0;
					if (emit) begin
						halfword_index_q <= halfword_index_q + 7'd1;
					end
				end else begin
					partial_q <= {partial_q[7:0], nib};
				end
			end
		end
	end

endmodule

/* hw/rtl/hrfh_queue.sv */
// Small FIFO between the parser and the address stage.
`timescale 1ns / 1ps

module hrfh_queue import hrfh_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  hrfh_entry_t  push_entry,
	output logic         push_ready,
	output logic         pop_valid,
	output hrfh_entry_t  pop_entry,
	input  logic         pop_ready
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	hrfh_entry_t     slots_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CntFull;
	assign pop_valid = count_q != '0;
	assign pop_entry = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* hw/rtl/hrfh_back.sv */
// Address stage: forms base OR offset plus halfword step, holds the output register.
`timescale 1ns / 1ps

module hrfh_back import hrfh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] flash_base,
	input  logic              pop_valid,
	input  hrfh_entry_t       pop_entry,
	output logic              pop_ready,
	hrfh_out_if.source        words
);

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [HW_W-1:0]   out_hw_q;
	logic              out_last_q;
	logic [ADDR_W-1:0] addr;

	// Load when empty or when the held result transfers this cycle.
	assign pop_ready = !out_valid_q || words.ready;
	assign addr = (flash_base | {{(ADDR_W-OFFSET_W){1'b0}}, pop_entry.offset})
		+ {{(ADDR_W-IDX_W-1){1'b0}}, pop_entry.index, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			out_addr_q <= addr;
			out_hw_q <= pop_entry.halfword;
			out_last_q <= pop_entry.last;
		end
	end

	assign words.valid = out_valid_q;
	assign words.flash_address = out_addr_q;
	assign words.halfword = out_hw_q;
	assign words.last_of_record = out_last_q;

endmodule

/* hw/rtl/hex_record_to_flash_halfwords_unit.sv */
// Top level: hex data record characters in, flash halfword writes out.
//
//  Channel | Dir | Payload                                        | Transfer
//  --------+-----+------------------------------------------------+-------------------
//  chars   | in  | record_char[7:0], record_start                 | valid & ready
//  words   | out | flash_address[31:0], halfword[15:0], last_of_record | valid & ready
//  cfg     | in  | data[31:0] -> flash base address               | valid & ready (ready=1)
//
// One character is taken per cycle while the queue has room. A halfword is written
// into the queue by the character that completes it, then passes the address adder
// stage into the output register. Reset clears parser state, the queue and the output
// valid, and loads the flash base with 0x0800_0000. A stalled output fills the
// queue; only then does chars.ready drop, and it rises again as soon as an entry
// drains. Characters that produce no halfword are never held up by a stall
// unless the queue is full.
`timescale 1ns / 1ps

module hex_record_to_flash_halfwords_unit import hrfh_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	hrfh_in_if.sink     chars,
	hrfh_out_if.source  words,
	hrfh_cfg_if.sink    cfg
);

	logic [ADDR_W-1:0] flash_base_q;
	logic              push_valid;
	logic              push_ready;
	hrfh_entry_t       push_entry;
	logic              pop_valid;
	logic              pop_ready;
	hrfh_entry_t       pop_entry;

	// Base register: writes are always taken; they must arrive only while idle, which the block does not enforce.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_base_q <= FLASH_BASE_RST;
		end else if (cfg.valid) begin
			flash_base_q <= cfg.data;
		end
	end

	// Front: classify each character by position, assemble halfwords.
	hrfh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	// Decouple the parser from output backpressure.
	hrfh_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	// Back: compute the target address and hold the result for transfer.
	hrfh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.flash_base (flash_base_q),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready),
		.words      (words)
	);

endmodule
